// File: hw/rtl/atc_pkg.sv
// Shared types, constants and helpers of the assembler token classifier.
package atc_pkg;

  // Fixed field widths
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int MASK_W    = 11;
  localparam int NUM_W     = 64;
  localparam int SEL_W     = 16;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMM_PREFIX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_PREFIX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAB_PREFIX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_OPEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_CLOSE  = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_IMM_PREFIX = 8'd35;  // '#'
  localparam logic [CFG_W-1:0] RST_DIR_PREFIX = 8'd46;  // '.'
  localparam logic [CFG_W-1:0] RST_LAB_PREFIX = 8'd58;  // ':'
  localparam logic [CFG_W-1:0] RST_SEL_OPEN   = 8'd91;  // '['
  localparam logic [CFG_W-1:0] RST_SEL_CLOSE  = 8'd93;  // ']'

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [3:0]        HEX_TEN  = 4'd10;

  // Class mask bits
  localparam int CLS_TEXT      = 0;
  localparam int CLS_DECIMAL   = 1;
  localparam int CLS_HEX       = 2;
  localparam int CLS_NUMBER    = 3;
  localparam int CLS_IMMEDIATE = 4;
  localparam int CLS_DIRECTIVE = 5;
  localparam int CLS_LABEL     = 6;
  localparam int CLS_FILE      = 7;
  localparam int CLS_SELECT    = 8;
  localparam int CLS_BYTECONST = 9;
  localparam int CLS_BYTELABEL = 10;

  // Classified character word passed from front to back
  typedef struct packed {
    logic       tstart;   // letter or underscore
    logic       digit;
    logic       hexd;
    logic [3:0] nib;      // digit or hex digit value
    logic       zero;
    logic       ex;
    logic       minus;
    logic       plus;
    logic       dot;
    logic       imm;      // equals immediate prefix
    logic       dir;      // equals directive prefix
    logic       lab;      // equals label prefix
    logic       open;     // equals select open
    logic       close;    // equals select close
    logic       last;
  } word_t;

  // Number lane phase
  typedef enum logic [7:0] {
    PH_START  = 8'b0000_0001,
    PH_SIGNED = 8'b0000_0010,
    PH_ZERO   = 8'b0000_0100,
    PH_X      = 8'b0000_1000,
    PH_HEX    = 8'b0001_0000,
    PH_DEC    = 8'b0010_0000,
    PH_DEAD   = 8'b0100_0000,
    PH_WAIT   = 8'b1000_0000
  } phase_t;

  // File name recognizer state
  typedef enum logic [3:0] {
    FS_PRE  = 4'b0001,
    FS_V0   = 4'b0010,
    FS_V    = 4'b0100,
    FS_DEAD = 4'b1000
  } file_t;

  function automatic logic ph_number(phase_t p);
    return (p == PH_ZERO) || (p == PH_DEC) || (p == PH_HEX);
  endfunction

  function automatic logic ph_decimal(phase_t p);
    return (p == PH_ZERO) || (p == PH_DEC);
  endfunction

endpackage

// File: hw/rtl/atc_if.sv
// Valid/ready channel interfaces for characters and classification results.
interface atc_char_if import atc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_token;

  modport source (output valid, output char_code, output end_of_token, input ready);
  modport sink   (input valid, input char_code, input end_of_token, output ready);
endinterface

interface atc_result_if import atc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] class_mask;
  logic [NUM_W-1:0]  number_value;
  logic [SEL_W-1:0]  select_index;
  logic              value_overflow;

  modport source (output valid, output class_mask, output number_value,
                  output select_index, output value_overflow, input ready);
  modport sink   (input valid, input class_mask, input number_value,
                  input select_index, input value_overflow, output ready);
endinterface

// File: hw/rtl/atc_front.sv
// Front part: configuration registers and per-character classification.
module atc_front import atc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  atc_char_if.sink             chars,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_ready,
  output logic                 push,
  output word_t                word
);

  logic [CFG_W-1:0]  imm_prefix, dir_prefix, lab_prefix, sel_open, sel_close;
  logic [CHAR_W-1:0] c;
  logic              is_up, is_low, is_hex_up, is_hex_low;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      imm_prefix <= RST_IMM_PREFIX;
      dir_prefix <= RST_DIR_PREFIX;
      lab_prefix <= RST_LAB_PREFIX;
      sel_open   <= RST_SEL_OPEN;
      sel_close  <= RST_SEL_CLOSE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMM_PREFIX: imm_prefix <= cfg_data;
        REG_DIR_PREFIX: dir_prefix <= cfg_data;
        REG_LAB_PREFIX: lab_prefix <= cfg_data;
        REG_SEL_OPEN:   sel_open   <= cfg_data;
        REG_SEL_CLOSE:  sel_close  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Character classification
  always_comb begin
    c          = chars.char_code;
    is_up      = (c >= CH_UA) && (c <= CH_UZ);
    is_low     = (c >= CH_LA) && (c <= CH_LZ);
    is_hex_up  = (c >= CH_UA) && (c <= CH_UF);
    is_hex_low = (c >= CH_LA) && (c <= CH_LF);

    word        = '0;
    word.tstart = is_up || is_low || (c == CH_UNDER);
    word.digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    word.hexd   = word.digit || is_hex_up || is_hex_low;
    if (word.digit) begin
      word.nib = 4'(c - CH_ZERO);
    end else if (is_hex_low) begin
      word.nib = 4'(c - CH_LA) + HEX_TEN;
    end else if (is_hex_up) begin
      word.nib = 4'(c - CH_UA) + HEX_TEN;
    end
    word.zero  = (c == CH_ZERO);
    word.ex    = (c == CH_X);
    word.minus = (c == CH_MINUS);
    word.plus  = (c == CH_PLUS);
    word.dot   = (c == CH_DOT);
    word.imm   = (c == imm_prefix);
    word.dir   = (c == dir_prefix);
    word.lab   = (c == lab_prefix);
    word.open  = (c == sel_open);
    word.close = (c == sel_close);
    word.last  = chars.end_of_token;
  end

  assign chars.ready = q_ready;
  assign push        = chars.valid && q_ready;

endmodule

// File: hw/rtl/atc_queue.sv
// Short word queue between the front and the back part.
module atc_queue import atc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  output logic  q_ready,
  input  logic  pop,
  output logic  q_valid,
  output word_t q_word
);

  word_t            slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [Q_CW-1:0]  count;

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign q_ready = (count != Q_CW'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_word  = slots[rd_ptr];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue count above depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Q_CW'(Q_DEPTH)))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

endmodule

// File: hw/rtl/atc_lane.sv
// One number lane: sign, zero/hex/decimal phases and saturating accumulator.
module atc_lane import atc_pkg::*; #(
  parameter int             W     = 64,
  parameter logic [W-1:0]   LIMIT = '1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         clear,
  input  phase_t       init,
  input  word_t        ch,
  output phase_t       phase,
  output phase_t       phase_next,
  output logic [W-1:0] mag,
  output logic [W-1:0] mag_next,
  output logic         neg_next,
  output logic         ovf,
  output logic         ovf_next
);

  logic         neg;
  logic         acc;
  logic [W:0]   lim;
  logic [W+4:0] prod_dec, prod_hex, prod;

  // Next phase and saturating multiply-add
  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc        = 1'b0;
    lim        = (W+1)'(LIMIT) + (W+1)'(neg);
    prod_dec   = (W+5)'({mag, 3'b000}) + (W+5)'({mag, 1'b0}) + (W+5)'(ch.nib);
    prod_hex   = (W+5)'({mag, 4'b0000}) + (W+5)'(ch.nib);

    unique case (phase) inside
      PH_WAIT: begin
        phase_next = ch.imm ? PH_START : PH_DEAD;
      end
      PH_START, PH_SIGNED: begin
        if (phase == PH_START && ch.minus) begin
          neg_next   = 1'b1;
          phase_next = PH_SIGNED;
        end else if (phase == PH_START && ch.plus) begin
          phase_next = PH_SIGNED;
        end else if (ch.zero) begin
          phase_next = PH_ZERO;
        end else if (ch.digit) begin
          phase_next = PH_DEC;
          acc        = 1'b1;
        end else begin
          phase_next = PH_DEAD;
        end
      end
      PH_ZERO: begin
        phase_next = ch.ex ? PH_X : PH_DEAD;
      end
      PH_X, PH_HEX: begin
        if (ch.hexd) begin
          phase_next = PH_HEX;
          acc        = 1'b1;
        end else begin
          phase_next = PH_DEAD;
        end
      end
      PH_DEC: begin
        if (ch.digit) begin
          acc = 1'b1;
        end else begin
          phase_next = PH_DEAD;
        end
      end
      PH_DEAD: ;
      default: phase_next = phase;
    endcase

    prod     = ((phase == PH_X) || (phase == PH_HEX)) ? prod_hex : prod_dec;
    mag_next = mag;
    ovf_next = ovf;
    if (acc) begin
      if (prod > (W+5)'(lim)) begin
        mag_next = W'(lim);
        ovf_next = 1'b1;
      end else begin
        mag_next = W'(prod);
      end
    end
  end

  // Lane state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase <= init;
      mag   <= '0;
      neg   <= 1'b0;
      ovf   <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      mag   <= mag_next;
      neg   <= neg_next;
      ovf   <= ovf_next;
    end
  end

endmodule

// File: hw/rtl/atc_back.sv
// Back part: recognizers per token, result assembly and output stages.
module atc_back import atc_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int INDEX_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  word_t      q_word,
  output logic       pop,
  atc_result_if.source results
);

  localparam logic [VALUE_WIDTH-1:0] VAL_LIMIT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [INDEX_WIDTH-1:0] IDX_LIMIT = {INDEX_WIDTH{1'b1}};

  // Per-token recognizer state
  logic [7:0] pos;
  logic       al_text, al_dir, al_lab;
  file_t      file_st, file_n;
  logic       split_seen, split_sel, split_bc, split_bl;

  logic       text_n, dir_n, lab_n, tcont, pos_zero, dl_ok;
  logic       done, body_hit, sel, bc, bl;
  logic       s1_ready, s2_ready;

  // Lane views
  phase_t                 num_ph_n, imm_ph_n, uns_ph_n, body_ph;
  logic [VALUE_WIDTH-1:0] num_mag_n, imm_mag_n;
  logic                   num_neg_n, imm_neg_n, num_ovf_n, imm_ovf_n;
  logic [INDEX_WIDTH-1:0] body_mag;
  logic                   body_ovf;

  // Assembled result
  logic [MASK_W-1:0]      mask_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic                   neg_r, ovf_r;
  logic [INDEX_WIDTH-1:0] idx_r;

  // Output stage 1: raw result
  logic                   v1;
  logic [MASK_W-1:0]      mask1;
  logic [VALUE_WIDTH-1:0] mag1;
  logic                   neg1, ovf1;
  logic [INDEX_WIDTH-1:0] idx1;

  // Output stage 2: final word
  logic                   v2;
  logic [MASK_W-1:0]      mask2;
  logic [NUM_W-1:0]       value2;
  logic [SEL_W-1:0]       idx2;
  logic                   ovf2;

  assign s2_ready = !v2 || results.ready;
  assign s1_ready = !v1 || s2_ready;
  assign pop      = q_valid && (!q_word.last || s1_ready);
  assign done     = pop && q_word.last;

  // Number lanes: signed number, immediate, unsigned, bracket body
  atc_lane #(.W(VALUE_WIDTH), .LIMIT(VAL_LIMIT)) u_num (
    .clk, .rst, .step(pop), .clear(done), .init(PH_START), .ch(q_word),
    .phase(), .phase_next(num_ph_n), .mag(), .mag_next(num_mag_n),
    .neg_next(num_neg_n), .ovf(), .ovf_next(num_ovf_n)
  );

  atc_lane #(.W(VALUE_WIDTH), .LIMIT(VAL_LIMIT)) u_imm (
    .clk, .rst, .step(pop), .clear(done), .init(PH_WAIT), .ch(q_word),
    .phase(), .phase_next(imm_ph_n), .mag(), .mag_next(imm_mag_n),
    .neg_next(imm_neg_n), .ovf(), .ovf_next(imm_ovf_n)
  );

  atc_lane #(.W(VALUE_WIDTH), .LIMIT(VAL_LIMIT)) u_uns (
    .clk, .rst, .step(pop), .clear(done), .init(PH_SIGNED), .ch(q_word),
    .phase(), .phase_next(uns_ph_n), .mag(), .mag_next(),
    .neg_next(), .ovf(), .ovf_next()
  );

  atc_lane #(.W(INDEX_WIDTH), .LIMIT(IDX_LIMIT)) u_body (
    .clk, .rst, .step(pop && split_seen), .clear(done), .init(PH_SIGNED), .ch(q_word),
    .phase(body_ph), .phase_next(), .mag(body_mag), .mag_next(),
    .neg_next(), .ovf(body_ovf), .ovf_next()
  );

  // Text, directive, label and file recognizers
  always_comb begin
    tcont    = q_word.tstart || q_word.digit;
    pos_zero = (pos == '0);
    dl_ok    = (pos == 8'd1) ? q_word.tstart : tcont;
    text_n   = al_text && (pos_zero ? q_word.tstart : tcont);
    dir_n    = al_dir  && (pos_zero ? q_word.dir : dl_ok);
    lab_n    = al_lab  && (pos_zero ? q_word.lab : dl_ok);

    file_n = file_st;
    unique case (file_st)
      FS_PRE:  if (q_word.dot) file_n = (al_text && !pos_zero) ? FS_V0 : FS_DEAD;
      FS_V0:   file_n = q_word.tstart ? FS_V : FS_DEAD;
      FS_V:    if (!tcont) file_n = FS_DEAD;
      FS_DEAD: ;
      default: file_n = file_st;
    endcase
  end

  // Result assembly on the last character
  always_comb begin
    body_hit = split_seen && ph_decimal(body_ph) && q_word.close;
    sel      = body_hit && split_sel;
    bc       = body_hit && split_bc;
    bl       = body_hit && split_bl;

    mask_r                = '0;
    mask_r[CLS_TEXT]      = text_n;
    mask_r[CLS_DECIMAL]   = ph_decimal(uns_ph_n);
    mask_r[CLS_HEX]       = (uns_ph_n == PH_HEX);
    mask_r[CLS_NUMBER]    = ph_number(num_ph_n);
    mask_r[CLS_IMMEDIATE] = ph_number(imm_ph_n);
    mask_r[CLS_DIRECTIVE] = dir_n && !pos_zero;
    mask_r[CLS_LABEL]     = lab_n && !pos_zero;
    mask_r[CLS_FILE]      = (file_n == FS_V);
    mask_r[CLS_SELECT]    = sel;
    mask_r[CLS_BYTECONST] = bc;
    mask_r[CLS_BYTELABEL] = bl;

    mag_r = '0;
    neg_r = 1'b0;
    ovf_r = 1'b0;
    if (ph_number(num_ph_n)) begin
      mag_r = num_mag_n;
      neg_r = num_neg_n;
      ovf_r = num_ovf_n;
    end else if (ph_number(imm_ph_n)) begin
      mag_r = imm_mag_n;
      neg_r = imm_neg_n;
      ovf_r = imm_ovf_n;
    end

    idx_r = '0;
    if (sel || bc || bl) begin
      idx_r = body_mag;
      ovf_r = ovf_r || body_ovf;
    end
  end

  // Recognizer state update, cleared after each token
  always_ff @(posedge clk) begin
    if (rst || done) begin
      pos        <= '0;
      al_text    <= 1'b1;
      al_dir     <= 1'b1;
      al_lab     <= 1'b1;
      file_st    <= FS_PRE;
      split_seen <= 1'b0;
      split_sel  <= 1'b0;
      split_bc   <= 1'b0;
      split_bl   <= 1'b0;
    end else if (pop) begin
      if (pos != 8'hFF) begin
        pos <= pos + 8'd1;
      end
      al_text <= text_n;
      al_dir  <= dir_n;
      al_lab  <= lab_n;
      file_st <= file_n;
      // split at the first select open
      if (!split_seen && q_word.open) begin
        split_seen <= 1'b1;
        split_sel  <= pos_zero;
        split_bc   <= al_text && !pos_zero;
        split_bl   <= al_lab && (pos >= 8'd2);
      end
    end
  end

  // Output stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (done) begin
        v1 <= 1'b1;
      end else if (s2_ready) begin
        v1 <= 1'b0;
      end
      if (s2_ready) begin
        v2 <= v1;
      end
    end
  end

  // Output stage payloads; sign applied in stage 2
  always_ff @(posedge clk) begin
    if (done) begin
      mask1 <= mask_r;
      mag1  <= mag_r;
      neg1  <= neg_r;
      ovf1  <= ovf_r;
      idx1  <= idx_r;
    end
    if (s2_ready && v1) begin
      mask2  <= mask1;
      value2 <= neg1 ? (NUM_W'(0) - NUM_W'(mag1)) : NUM_W'(mag1);
      idx2   <= SEL_W'(idx1);
      ovf2   <= ovf1;
    end
  end

  assign results.valid          = v2;
  assign results.class_mask     = mask2;
  assign results.number_value   = value2;
  assign results.select_index   = idx2;
  assign results.value_overflow = ovf2;

  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    done |=> (pos == '0) && !split_seen)
    else $error("token state not cleared after last character");
  a_split_flags: assert property (@(posedge clk) disable iff (rst)
    !split_seen |-> !(split_sel || split_bc || split_bl))
    else $error("select split flags set without a split");
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (v1 && !mask1[CLS_SELECT] && !mask1[CLS_BYTECONST] && !mask1[CLS_BYTELABEL])
      |-> (idx1 == '0))
    else $error("select index without a select class");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop without a queued word");

endmodule

// File: hw/rtl/assembler_token_classifier.sv
// Assembler token classifier: characters in, one class word per token out.
//
// Channels: "chars" takes one character word per handshake (char_code and
// end_of_token on the last character of a token). "results" gives one word
// per token: class_mask, number_value, select_index and value_overflow.
// The cfg_write / cfg_index / cfg_data port sets the five prefix and bracket
// characters; write only while no token is in flight.
// Throughput: one character per cycle while the result stages are not stalled.
// Each character updates the back part's number lanes, a multiply by ten or
// sixteen (shift and add) with a saturating compare in each number lane.
// With the queue empty, once the last character is accepted the result word
// passes the queue slot, the result stage and the output stage in that order
// before it turns valid.
// Reset (rst, synchronous): registers return to '#', '.', ':', '[' and ']',
// the queue empties and all per-token state clears.
// When the receiver stalls, two finished results are held in the output
// stages, characters of the next token keep flowing, and chars.ready drops
// once the two-word queue is full behind a pending last character.
module assembler_token_classifier import atc_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  atc_char_if.sink             chars,
  atc_result_if.source         results,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic  q_ready, push, pop, q_valid;
  word_t push_word, q_word;

  atc_front u_front (
    .clk, .rst, .chars, .cfg_write, .cfg_index, .cfg_data,
    .q_ready, .push, .word(push_word)
  );

  atc_queue u_queue (
    .clk, .rst, .push, .push_word, .q_ready, .pop, .q_valid, .q_word
  );

  atc_back #(.VALUE_WIDTH(VALUE_WIDTH), .INDEX_WIDTH(INDEX_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_word, .pop, .results
  );

endmodule
